// ----- rtl/awt_pkg.sv -----
package awt_pkg;

	localparam int CHAR_BITS     = 16;
	localparam int MAX_TAG_LEVEL = 15;

	localparam int LVL_W = $clog2(MAX_TAG_LEVEL + 1);

	localparam logic [15:0] CHAR_MASK =
		(CHAR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << CHAR_BITS) - 32'd1);

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] CFG_WORD_SEP = 2'd0;
	localparam logic [1:0] CFG_TAG_SEP  = 2'd1;
	localparam logic [1:0] CFG_ALT_SEP  = 2'd2;
	localparam logic [1:0] CFG_ESCAPE   = 2'd3;

	localparam logic [15:0] RST_WORD_SEP = 16'd32;
	localparam logic [15:0] RST_TAG_SEP  = 16'd47;
	localparam logic [15:0] RST_ALT_SEP  = 16'd38;
	localparam logic [15:0] RST_ESCAPE   = 16'd92;

	typedef enum logic [2:0] {
		EV_WCHAR = 3'd0,
		EV_TCHAR = 3'd1,
		EV_TEND  = 3'd2,
		EV_WEND  = 3'd3,
		EV_LEND  = 3'd4,
		EV_ERR   = 3'd5
	} ev_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_SEP     = 2'd1,
		ERR_ESCAPE  = 2'd2,
		ERR_EMPTY   = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		PH_WORD    = 3'b001,
		PH_TAG     = 3'b010,
		PH_DISCARD = 3'b100
	} phase_t;

	typedef struct packed {
		logic        ev0_v;
		ev_kind_t    ev0_kind;
		logic [15:0] ev0_char;
		logic [3:0]  ev0_lvl;
		err_t        ev0_err;
		logic        wend_v;
		logic        lend_v;
	} bundle_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [3:0] lvl_report(input logic [LVL_W-1:0] lvl);
		logic [LVL_W+3:0] wide;
		wide = {4'b0000, lvl};
		return wide[3:0];
	endfunction

endpackage

// ----- rtl/awt_front.sv -----
module awt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            char_valid,
	output logic            char_stall,
	input  logic [15:0]     char_code,
	input  logic            line_end,
	input  awt_pkg::q_stat_t q_stat,
	output logic            push,
	output awt_pkg::bundle_t bundle
);

	logic [15:0] word_sep_q;
	logic [15:0] tag_sep_q;
	logic [15:0] alt_sep_q;
	logic [15:0] escape_q;

	awt_pkg::phase_t           phase_q, phase_d;
	logic                      esc_q, esc_d;
	logic                      word_has_q, word_has_d;
	logic                      tag_has_q, tag_has_d;
	logic [awt_pkg::LVL_W-1:0] level_q, level_d;

	logic [15:0] c;
	logic        is_word, is_tag, is_alt, is_esc;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_sep_q <= awt_pkg::RST_WORD_SEP;
			tag_sep_q  <= awt_pkg::RST_TAG_SEP;
			alt_sep_q  <= awt_pkg::RST_ALT_SEP;
			escape_q   <= awt_pkg::RST_ESCAPE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				awt_pkg::CFG_WORD_SEP: word_sep_q <= cfg_data;
				awt_pkg::CFG_TAG_SEP:  tag_sep_q  <= cfg_data;
				awt_pkg::CFG_ALT_SEP:  alt_sep_q  <= cfg_data;
				awt_pkg::CFG_ESCAPE:   escape_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign c       = char_code & awt_pkg::CHAR_MASK;
	assign is_word = (c == (word_sep_q & awt_pkg::CHAR_MASK));
	assign is_tag  = (c == (tag_sep_q & awt_pkg::CHAR_MASK));
	assign is_alt  = (c == (alt_sep_q & awt_pkg::CHAR_MASK));
	assign is_esc  = (c == (escape_q & awt_pkg::CHAR_MASK));

	always_comb begin
		phase_d    = phase_q;
		esc_d      = esc_q;
		word_has_d = word_has_q;
		tag_has_d  = tag_has_q;
		level_d    = level_q;
		bundle     = '0;
		bundle.ev0_kind = awt_pkg::EV_WCHAR;
		bundle.ev0_err  = awt_pkg::ERR_NONE;

		unique case (phase_q)
			awt_pkg::PH_WORD: begin
				if (esc_q) begin
					esc_d           = 1'b0;
					bundle.ev0_v    = 1'b1;
					bundle.ev0_kind = awt_pkg::EV_WCHAR;
					bundle.ev0_char = c;
					word_has_d      = 1'b1;
				end else if (is_word) begin
					if (word_has_q) begin
						bundle.ev0_v    = 1'b1;
						bundle.ev0_kind = awt_pkg::EV_WEND;
						word_has_d      = 1'b0;
					end
				end else if (is_tag) begin
					if (word_has_q) begin
						phase_d   = awt_pkg::PH_TAG;
						level_d   = '0;
						tag_has_d = 1'b0;
					end else begin
						bundle.ev0_v    = 1'b1;
						bundle.ev0_kind = awt_pkg::EV_ERR;
						bundle.ev0_err  = awt_pkg::ERR_EMPTY;
						phase_d         = awt_pkg::PH_DISCARD;
					end
				end else if (is_alt) begin
					bundle.ev0_v    = 1'b1;
					bundle.ev0_kind = awt_pkg::EV_ERR;
					bundle.ev0_err  = awt_pkg::ERR_SEP;
					phase_d         = awt_pkg::PH_DISCARD;
				end else if (is_esc) begin
					if (line_end) begin
						bundle.ev0_v    = 1'b1;
						bundle.ev0_kind = awt_pkg::EV_ERR;
						bundle.ev0_err  = awt_pkg::ERR_ESCAPE;
						phase_d         = awt_pkg::PH_DISCARD;
					end else begin
						esc_d = 1'b1;
					end
				end else begin
					bundle.ev0_v    = 1'b1;
					bundle.ev0_kind = awt_pkg::EV_WCHAR;
					bundle.ev0_char = c;
					word_has_d      = 1'b1;
				end
			end
			awt_pkg::PH_TAG: begin
				if (esc_q) begin
					esc_d           = 1'b0;
					bundle.ev0_v    = 1'b1;
					bundle.ev0_kind = awt_pkg::EV_TCHAR;
					bundle.ev0_char = c;
					bundle.ev0_lvl  = awt_pkg::lvl_report(level_q);
					tag_has_d       = 1'b1;
				end else if (is_word) begin
					bundle.ev0_v    = 1'b1;
					bundle.ev0_kind = awt_pkg::EV_WEND;
					phase_d         = awt_pkg::PH_WORD;
					word_has_d      = 1'b0;
					tag_has_d       = 1'b0;
					level_d         = '0;
				end else if (is_tag || is_alt) begin
					if (tag_has_q) begin
						bundle.ev0_v    = 1'b1;
						bundle.ev0_kind = awt_pkg::EV_TEND;
						bundle.ev0_lvl  = awt_pkg::lvl_report(level_q);
					end
					tag_has_d = 1'b0;
					if (is_tag &&
					    (level_q < awt_pkg::LVL_W'(awt_pkg::MAX_TAG_LEVEL))) begin
						level_d = level_q + 1'b1;
					end
				end else if (is_esc) begin
					if (line_end) begin
						bundle.ev0_v    = 1'b1;
						bundle.ev0_kind = awt_pkg::EV_ERR;
						bundle.ev0_err  = awt_pkg::ERR_ESCAPE;
						phase_d         = awt_pkg::PH_DISCARD;
					end else begin
						esc_d = 1'b1;
					end
				end else begin
					bundle.ev0_v    = 1'b1;
					bundle.ev0_kind = awt_pkg::EV_TCHAR;
					bundle.ev0_char = c;
					bundle.ev0_lvl  = awt_pkg::lvl_report(level_q);
					tag_has_d       = 1'b1;
				end
			end
			default: begin
				phase_d = awt_pkg::PH_DISCARD;
			end
		endcase

		if (phase_d == awt_pkg::PH_DISCARD) begin
			esc_d = 1'b0;
		end

		if (line_end) begin
			bundle.wend_v = ((phase_d == awt_pkg::PH_WORD) && word_has_d) ||
			                (phase_d == awt_pkg::PH_TAG);
			bundle.lend_v = 1'b1;
			phase_d    = awt_pkg::PH_WORD;
			esc_d      = 1'b0;
			word_has_d = 1'b0;
			tag_has_d  = 1'b0;
			level_d    = '0;
		end
	end

	assign char_stall = q_stat.full;
	assign accept     = char_valid && !q_stat.full;
	assign push       = accept && (bundle.ev0_v || bundle.lend_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= awt_pkg::PH_WORD;
			esc_q      <= 1'b0;
			word_has_q <= 1'b0;
			tag_has_q  <= 1'b0;
			level_q    <= '0;
		end else if (accept) begin
			phase_q    <= phase_d;
			esc_q      <= esc_d;
			word_has_q <= word_has_d;
			tag_has_q  <= tag_has_d;
			level_q    <= level_d;
		end
	end

endmodule

// ----- rtl/awt_queue.sv -----
module awt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  awt_pkg::bundle_t push_data,
	input  logic             pop,
	output awt_pkg::bundle_t head,
	output awt_pkg::q_stat_t q_stat
);

	awt_pkg::bundle_t            mem_q [awt_pkg::Q_DEPTH];
	logic [awt_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [awt_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [awt_pkg::Q_CNT_W-1:0] count_q;
	logic                        do_push, do_pop;

	function automatic logic [awt_pkg::Q_PTR_W-1:0] ptr_next(
		input logic [awt_pkg::Q_PTR_W-1:0] p);
		return (p == awt_pkg::Q_PTR_W'(awt_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == awt_pkg::Q_CNT_W'(awt_pkg::Q_DEPTH));
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/awt_back.sv -----
module awt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  awt_pkg::bundle_t head,
	input  awt_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             event_valid,
	input  logic             event_stall,
	output logic [2:0]       event_kind,
	output logic [15:0]      char_value,
	output logic [3:0]       tag_level,
	output logic [1:0]       error_code,
	output logic             run_last
);

	logic [2:0]  done_q;
	logic [2:0]  pend;
	logic [2:0]  sel;
	logic        last;
	logic        load;
	logic        out_v_q;
	logic [2:0]  kind_d;
	logic [15:0] char_d;
	logic [3:0]  lvl_d;
	logic [1:0]  err_d;

	assign pend = q_stat.empty ? 3'b000 :
	              ({head.lend_v, head.wend_v, head.ev0_v} & ~done_q);

	always_comb begin
		sel    = 3'b000;
		kind_d = 3'(awt_pkg::EV_LEND);
		char_d = '0;
		lvl_d  = '0;
		err_d  = 2'(awt_pkg::ERR_NONE);
		priority if (pend[0]) begin
			sel    = 3'b001;
			kind_d = 3'(head.ev0_kind);
			char_d = head.ev0_char;
			lvl_d  = head.ev0_lvl;
			err_d  = 2'(head.ev0_err);
		end else if (pend[1]) begin
			sel    = 3'b010;
			kind_d = 3'(awt_pkg::EV_WEND);
		end else if (pend[2]) begin
			sel    = 3'b100;
			kind_d = 3'(awt_pkg::EV_LEND);
		end else begin
			sel    = 3'b000;
		end
	end

	assign last = ((pend & ~sel) == 3'b000);
	assign load = (pend != 3'b000) && (!out_v_q || !event_stall);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 3'b000;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				done_q  <= last ? 3'b000 : (done_q | sel);
				out_v_q <= 1'b1;
			end else if (!event_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			event_kind <= kind_d;
			char_value <= char_d;
			tag_level  <= lvl_d;
			error_code <= err_d;
			run_last   <= last;
		end
	end

	assign event_valid = out_v_q;

endmodule

// ----- rtl/annotated_word_tag_tokenizer.sv -----
// Annotated word and tag tokenizer.
// Input channel (char_valid/char_stall): one mapped character per request,
// with line_end set on the last character of a line.
// Output channel (event_valid/event_stall): one event per request, carrying
// event_kind, char_value, tag_level, error_code and run_last; run_last marks
// the final event caused by one character.
// Configuration: cfg_we with cfg_index and cfg_data writes one separator or
// the escape code; write only while the block is idle.
// The events of a character pass through the queue and then the output
// register before they appear on event_valid.
// Throughput: one character per cycle while each character causes at most
// one event and event_stall is low; a character causing more events holds
// the output serialiser until each is sent. A four-entry queue between the
// parser and the serialiser absorbs such bursts before char_stall rises.
// Reset: all separators return to their defaults, the parser returns to the
// start of a line and the queue and output register empty.
// When event_stall is high the output event holds and the queue fills; once
// it is full char_stall is raised until the serialiser drains an entry.
module annotated_word_tag_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [15:0] char_code,
	input  logic        line_end,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [2:0]  event_kind,
	output logic [15:0] char_value,
	output logic [3:0]  tag_level,
	output logic [1:0]  error_code,
	output logic        run_last
);

	awt_pkg::bundle_t push_data;
	awt_pkg::bundle_t head;
	awt_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	awt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.line_end   (line_end),
		.q_stat     (q_stat),
		.push       (push),
		.bundle     (push_data)
	);

	awt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	awt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_kind  (event_kind),
		.char_value  (char_value),
		.tag_level   (tag_level),
		.error_code  (error_code),
		.run_last    (run_last)
	);

`ifndef ASSERT_OFF
	a_line_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall && line_end) |=> !q_stat.empty)
		else $error("line end accepted but queue empty");

	a_lend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && (event_kind == 3'(awt_pkg::EV_LEND))) |-> run_last)
		else $error("line end event not marked last");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && (event_kind != 3'(awt_pkg::EV_WCHAR)) &&
		 (event_kind != 3'(awt_pkg::EV_TCHAR))) |-> (char_value == 16'd0))
		else $error("char value set on non-character event");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> event_valid && run_last)
		else $error("bundle retired without its last event");
`endif

endmodule

// ----- verif/annotated_word_tag_tokenizer_tb.sv -----
module annotated_word_tag_tokenizer_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_SETTLE  = 20;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		awt_pkg::ev_kind_t kind;
		logic [15:0]       chr;
		logic [3:0]        lvl;
		awt_pkg::err_t     err;
		logic              is_last;
	} tok_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = awt_pkg::CFG_WORD_SEP;
	logic [15:0] cfg_data = 16'd0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [15:0] char_code = 16'd0;
	logic        line_end = 1'b0;
	logic        event_valid;
	logic        event_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [15:0] char_value;
	logic [3:0]  tag_level;
	logic [1:0]  error_code;
	logic        run_last;

	annotated_word_tag_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.line_end(line_end),
		.event_valid(event_valid),
		.event_stall(event_stall),
		.event_kind(event_kind),
		.char_value(char_value),
		.tag_level(tag_level),
		.error_code(error_code),
		.run_last(run_last)
	);

	always #6 clk = ~clk;

	logic [15:0] sep_word = awt_pkg::RST_WORD_SEP;
	logic [15:0] sep_tag  = awt_pkg::RST_TAG_SEP;
	logic [15:0] sep_alt  = awt_pkg::RST_ALT_SEP;
	logic [15:0] esc_code = awt_pkg::RST_ESCAPE;

	awt_pkg::phase_t           parse_state = awt_pkg::PH_WORD;
	logic                      esc_pending = 1'b0;
	logic                      word_open = 1'b0;
	logic                      tag_open = 1'b0;
	logic [awt_pkg::LVL_W-1:0] cur_level = '0;

	tok_event_t  step_events[$];
	tok_event_t  expected_events[$];
	logic [15:0] line_chars[$];

	int cycle_count = 0;
	int mismatches = 0;
	int events_checked = 0;
	int chars_sent = 0;
	int settings_used = 1;
	bit quiet = 1'b0;
	int hold_req = 0;
	int hold_left = 0;
	int burst_left = 0;

	function automatic void add_event(awt_pkg::ev_kind_t kind, logic [15:0] chr,
			logic [3:0] lvl, awt_pkg::err_t err);
		tok_event_t ev;
		ev.kind = kind;
		ev.chr = chr;
		ev.lvl = lvl;
		ev.err = err;
		ev.is_last = 1'b0;
		step_events = {step_events, ev};
	endfunction

	function automatic void emit_literal(logic [15:0] c);
		if (parse_state == awt_pkg::PH_WORD) begin
			add_event(awt_pkg::EV_WCHAR, c, 4'd0, awt_pkg::ERR_NONE);
			word_open = 1'b1;
		end else begin
			add_event(awt_pkg::EV_TCHAR, c, 4'(cur_level), awt_pkg::ERR_NONE);
			tag_open = 1'b1;
		end
	endfunction

	function automatic void flag_error(awt_pkg::err_t code);
		add_event(awt_pkg::EV_ERR, 16'd0, 4'd0, code);
		parse_state = awt_pkg::PH_DISCARD;
		esc_pending = 1'b0;
	endfunction

	function automatic void clear_line_state();
		parse_state = awt_pkg::PH_WORD;
		esc_pending = 1'b0;
		word_open = 1'b0;
		tag_open = 1'b0;
		cur_level = '0;
	endfunction

	function automatic void tokenize_char(logic [15:0] code, logic le);
		logic [15:0] c;
		c = code & awt_pkg::CHAR_MASK;
		step_events.delete();
		if (parse_state != awt_pkg::PH_DISCARD) begin
			if (esc_pending) begin
				esc_pending = 1'b0;
				emit_literal(c);
			end else if (parse_state == awt_pkg::PH_WORD) begin
				if (c == (sep_word & awt_pkg::CHAR_MASK)) begin
					if (word_open) begin
						add_event(awt_pkg::EV_WEND, 16'd0, 4'd0, awt_pkg::ERR_NONE);
						word_open = 1'b0;
					end
				end else if (c == (sep_tag & awt_pkg::CHAR_MASK)) begin
					if (word_open) begin
						parse_state = awt_pkg::PH_TAG;
						cur_level = '0;
						tag_open = 1'b0;
					end else begin
						flag_error(awt_pkg::ERR_EMPTY);
					end
				end else if (c == (sep_alt & awt_pkg::CHAR_MASK)) begin
					flag_error(awt_pkg::ERR_SEP);
				end else if (c == (esc_code & awt_pkg::CHAR_MASK)) begin
					if (le)
						flag_error(awt_pkg::ERR_ESCAPE);
					else
						esc_pending = 1'b1;
				end else begin
					emit_literal(c);
				end
			end else begin
				if (c == (sep_word & awt_pkg::CHAR_MASK)) begin
					add_event(awt_pkg::EV_WEND, 16'd0, 4'd0, awt_pkg::ERR_NONE);
					parse_state = awt_pkg::PH_WORD;
					word_open = 1'b0;
					tag_open = 1'b0;
					cur_level = '0;
				end else if (c == (sep_tag & awt_pkg::CHAR_MASK)) begin
					if (tag_open)
						add_event(awt_pkg::EV_TEND, 16'd0, 4'(cur_level),
							awt_pkg::ERR_NONE);
					tag_open = 1'b0;
					if (cur_level < awt_pkg::MAX_TAG_LEVEL)
						cur_level = cur_level + 1'b1;
				end else if (c == (sep_alt & awt_pkg::CHAR_MASK)) begin
					if (tag_open)
						add_event(awt_pkg::EV_TEND, 16'd0, 4'(cur_level),
							awt_pkg::ERR_NONE);
					tag_open = 1'b0;
				end else if (c == (esc_code & awt_pkg::CHAR_MASK)) begin
					if (le)
						flag_error(awt_pkg::ERR_ESCAPE);
					else
						esc_pending = 1'b1;
				end else begin
					emit_literal(c);
				end
			end
		end
		if (le) begin
			if ((parse_state == awt_pkg::PH_WORD && word_open) ||
					parse_state == awt_pkg::PH_TAG)
				add_event(awt_pkg::EV_WEND, 16'd0, 4'd0, awt_pkg::ERR_NONE);
			add_event(awt_pkg::EV_LEND, 16'd0, 4'd0, awt_pkg::ERR_NONE);
			clear_line_state();
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].is_last = 1'b1;
		foreach (step_events[i])
			expected_events = {expected_events, step_events[i]};
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events outstanding", cycle_count,
				expected_events.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			event_stall <= 1'b0;
		end else begin
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				event_stall <= 1'b1;
			end else if (quiet) begin
				event_stall <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				event_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(0, 14);
				event_stall <= 1'b1;
			end else begin
				event_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tok_event_t ev;
		if (arst_n && event_valid && !event_stall) begin
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected event: kind %0d char %h level %0d err %0d last %0b",
						event_kind, char_value, tag_level, error_code, run_last);
			end else begin
				ev = expected_events.pop_front();
				events_checked++;
				if (event_kind !== ev.kind || char_value !== ev.chr || tag_level !== ev.lvl ||
						error_code !== ev.err || run_last !== ev.is_last) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"event %0d mismatch (expected/actual): kind %0d/%0d ",
							"char %h/%h level %0d/%0d err %0d/%0d last %0b/%0b"},
							events_checked, ev.kind, event_kind, ev.chr, char_value,
							ev.lvl, tag_level, ev.err, error_code, ev.is_last, run_last);
				end
			end
		end
	end

	task automatic send_char(input logic [15:0] code, input logic le);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= code;
		line_end <= le;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		tokenize_char(code, le);
		chars_sent++;
	endtask

	task automatic wait_idle();
		char_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic set_separators(input logic [15:0] w, input logic [15:0] t,
			input logic [15:0] a, input logic [15:0] e);
		cfg_we <= 1'b1;
		cfg_index <= awt_pkg::CFG_WORD_SEP;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= awt_pkg::CFG_TAG_SEP;
		cfg_data <= t;
		@(posedge clk);
		cfg_index <= awt_pkg::CFG_ALT_SEP;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= awt_pkg::CFG_ESCAPE;
		cfg_data <= e;
		@(posedge clk);
		cfg_we <= 1'b0;
		sep_word = w;
		sep_tag = t;
		sep_alt = a;
		esc_code = e;
		settings_used++;
	endtask

	function automatic logic [15:0] any_code();
		case ($urandom_range(0, 9))
			0: return sep_word;
			1: return sep_tag;
			2: return sep_alt;
			3: return esc_code;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] plain_code();
		logic [15:0] v;
		do begin
			case ($urandom_range(0, 9))
				0: v = 16'h0000;
				1: v = 16'hFFFF;
				default: v = 16'($urandom);
			endcase
		end while (v == sep_word || v == sep_tag || v == sep_alt || v == esc_code);
		return v;
	endfunction

	function automatic void push_literal();
		if ($urandom_range(0, 7) == 0) begin
			line_chars = {line_chars, esc_code};
			line_chars = {line_chars, any_code()};
		end else begin
			line_chars = {line_chars, plain_code()};
		end
	endfunction

	function automatic void make_line(input bit noisy);
		int n_words;
		int n_groups;
		line_chars.delete();
		if (noisy) begin
			repeat ($urandom_range(1, 12)) line_chars = {line_chars, any_code()};
			return;
		end
		if ($urandom_range(0, 3) == 0)
			line_chars = {line_chars, sep_word};
		n_words = $urandom_range(1, 3);
		for (int w = 0; w < n_words; w++) begin
			repeat ($urandom_range(1, 3)) push_literal();
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(15, 18)) line_chars = {line_chars, sep_tag};
				line_chars = {line_chars, plain_code()};
			end else begin
				n_groups = $urandom_range(0, 3);
				for (int g = 0; g < n_groups; g++) begin
					line_chars = {line_chars,
						((g == 0 || $urandom_range(0, 2) != 0) ? sep_tag : sep_alt)};
					repeat ($urandom_range(0, 2)) push_literal();
				end
			end
			if (w != n_words - 1)
				repeat ($urandom_range(1, 2)) line_chars = {line_chars, sep_word};
		end
		if ($urandom_range(0, 4) == 0)
			line_chars[$urandom_range(0, line_chars.size() - 1)] = any_code();
		if ($urandom_range(0, 14) == 0)
			line_chars = {line_chars, esc_code};
	endfunction

	task automatic run_random_lines(input int target);
		int start;
		start = chars_sent;
		while (chars_sent - start < target) begin
			make_line($urandom_range(0, 5) == 0);
			foreach (line_chars[i])
				send_char(line_chars[i], i == line_chars.size() - 1);
		end
	endtask

	task automatic test_directed_rules();
		send_char(awt_pkg::RST_WORD_SEP, 1'b0);
		send_char(16'h0000, 1'b0);
		send_char(awt_pkg::RST_WORD_SEP, 1'b0);
		send_char(awt_pkg::RST_WORD_SEP, 1'b0);
		send_char(16'hFFFF, 1'b0);
		send_char(awt_pkg::RST_TAG_SEP, 1'b0);
		send_char(16'h0062, 1'b0);
		send_char(awt_pkg::RST_ALT_SEP, 1'b0);
		send_char(awt_pkg::RST_ALT_SEP, 1'b0);
		send_char(awt_pkg::RST_TAG_SEP, 1'b0);
		send_char(awt_pkg::RST_ESCAPE, 1'b0);
		send_char(awt_pkg::RST_TAG_SEP, 1'b1);
		send_char(16'h0061, 1'b0);
		send_char(awt_pkg::RST_ALT_SEP, 1'b0);
		send_char(16'h0078, 1'b0);
		send_char(16'h0079, 1'b1);
		send_char(awt_pkg::RST_TAG_SEP, 1'b1);
		send_char(16'h0071, 1'b0);
		send_char(awt_pkg::RST_ESCAPE, 1'b1);
		send_char(awt_pkg::RST_ESCAPE, 1'b0);
		send_char(awt_pkg::RST_ESCAPE, 1'b1);
		send_char(16'h0061, 1'b0);
		send_char(awt_pkg::RST_TAG_SEP, 1'b0);
		send_char(16'h0062, 1'b0);
		send_char(awt_pkg::RST_WORD_SEP, 1'b1);
	endtask

	task automatic test_default_lines();
		run_random_lines(60);
	endtask

	task automatic test_extreme_separators();
		wait_idle();
		set_separators(16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE);
		run_random_lines(50);
	endtask

	task automatic test_shared_codes();
		wait_idle();
		set_separators(16'h002C, 16'h002C, 16'h003B, 16'h003B);
		run_random_lines(35);
	endtask

	task automatic test_output_hold_off();
		wait_idle();
		set_separators(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		hold_req = 120;
		run_random_lines(35);
	endtask

	task automatic test_full_rate_tail();
		wait_idle();
		set_separators(awt_pkg::RST_WORD_SEP, awt_pkg::RST_TAG_SEP, awt_pkg::RST_ALT_SEP,
			awt_pkg::RST_ESCAPE);
		quiet = 1'b1;
		run_random_lines(65);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_rules();
		test_default_lines();
		test_extreme_separators();
		test_shared_codes();
		test_output_hold_off();
		test_full_rate_tail();
		wait_idle();
		$display("%0d characters sent over %0d separator settings, %0d events checked,",
			chars_sent, settings_used, events_checked);
		$display("including a long output hold-off and a full-rate tail");
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d events missing", mismatches,
				expected_events.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
